@@ rtl/pva_pkg.sv @@
// Package for the polyphonic voice allocator: sequencer state type,
// controller/datapath command and status words, and shared constants.
`timescale 1ns / 1ps
package pva_pkg;

    localparam int DEF_VOICES = 8;   // default voice pool size
    localparam int FIELD_W    = 7;   // velocity and pitch width
    localparam int OUT_W      = 3;   // reported voice number width

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;     // latch the event and restart the scan
        logic scan;     // examine one voice this cycle
        logic commit;   // update state and emit the result word
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_last;  // scan index is at the last voice
    } t_ctrl_stat;

endpackage

@@ rtl/pva_controller.sv @@
// Sequencer for the voice allocator: idle, one-voice-per-cycle scan, commit.
// Depends on pva_pkg for the state type and the command/status structs.
`timescale 1ns / 1ps
module pva_controller
    import pva_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_ctrl_stat i_stat,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.scan_last) n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

@@ rtl/pva_datapath.sv @@
// Datapath of the voice allocator: voice table, age list, scan index and
// result register. Depends on pva_pkg; driven by pva_controller commands.
`timescale 1ns / 1ps
module pva_datapath
    import pva_pkg::*;
#(
    parameter int VOICES = DEF_VOICES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl_cmd          i_cmd,
    output t_ctrl_stat         o_stat,
    input  logic [FIELD_W-1:0] i_velocity,
    input  logic [FIELD_W-1:0] i_pitch,
    output logic [OUT_W-1:0]   o_voice_index,
    output logic               o_valid
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic [FIELD_W-1:0] r_vel;
    logic [FIELD_W-1:0] r_pitch;
    logic [VW-1:0]      r_idx;
    logic               r_found;
    logic [VW-1:0]      r_chosen;

    logic [FIELD_W-1:0] r_voice_pitch [VOICES];
    logic [FIELD_W-1:0] r_voice_vel   [VOICES];
    logic [VOICES-1:0]  r_voice_busy;
    logic [VW-1:0]      r_age         [VOICES];
    logic [VOICES-1:0]  r_age_valid;

    logic [OUT_W-1:0]   r_out_idx;
    logic               r_out_valid;

    logic               note_off;
    logic               hit;
    logic               free;
    logic [VW-1:0]      final_idx;
    logic [VW+OUT_W-1:0] final_ext;

    assign note_off = (r_vel == '0);
    assign hit      = (r_voice_pitch[r_idx] == r_pitch);
    assign free     = !r_voice_busy[r_idx];

    always_comb begin
        if (note_off || r_found) begin
            final_idx = r_chosen;
        end else if (r_age_valid[0]) begin
            final_idx = r_age[0];  // steal the oldest allocation
        end else begin
            final_idx = '0;
        end
    end

    assign final_ext          = {{OUT_W{1'b0}}, final_idx};
    assign o_stat.scan_last   = (r_idx == VW'(VOICES - 1));

    // Event latch and scan state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vel    <= i_velocity;
            r_pitch  <= i_pitch;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_chosen <= '0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + VW'(1);
            if (note_off) begin
                if (hit) r_chosen <= r_idx;  // last match wins
            end else if (free && !r_found) begin
                r_found  <= 1'b1;
                r_chosen <= r_idx;
            end
        end
    end

    // Voice table: release during the scan, allocate at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICES; i++) begin
                r_voice_pitch[i] <= '0;
                r_voice_vel[i]   <= '0;
            end
            r_voice_busy <= '0;
        end else if (i_cmd.scan && note_off && hit) begin
            r_voice_vel[r_idx]  <= '0;
            r_voice_busy[r_idx] <= 1'b0;
        end else if (i_cmd.commit && !note_off) begin
            r_voice_pitch[final_idx] <= r_pitch;
            r_voice_vel[final_idx]   <= r_vel;
            r_voice_busy[final_idx]  <= 1'b1;
        end
    end

    // Age list: advance toward the head, push the allocated voice at the tail
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_valid <= '0;
        end else if (i_cmd.commit && !note_off) begin
            r_age_valid <= {1'b1, r_age_valid[VOICES-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !note_off) begin
            for (int i = 0; i < VOICES - 1; i++) begin
                r_age[i] <= r_age[i+1];
            end
            r_age[VOICES-1] <= final_idx;
        end
    end

    // Result word, shown for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_out_idx <= final_ext[OUT_W-1:0];
    end

    assign o_voice_index = r_out_idx;
    assign o_valid       = r_out_valid;

endmodule

@@ rtl/poly_voice_allocator.sv @@
// Polyphonic voice allocator with oldest-voice stealing.
// Usage: present i_velocity and i_pitch with start; the event word is
// taken at a clock edge where start is high and busy is low. Velocity zero
// is a note-off that releases every voice holding the pitch; any other
// velocity takes the lowest free voice, or steals the oldest allocation.
// Each event yields one result word: o_voice_index with o_valid high for
// exactly one cycle. The receiver cannot hold it off.
// Timing: the sequencer examines one voice per cycle in its scan state and
// then commits; busy stays high through the scan and the commit, and
// o_valid rises on the edge that drops busy. A new event is accepted only
// in a cycle where busy is low, so no new event is taken before the last
// one has produced its result word.
// Reset (synchronous, active low): all voices free with pitch and velocity
// zero, the age list empty, no result pending.
// Depends on pva_pkg, pva_controller and pva_datapath.
`timescale 1ns / 1ps
module poly_voice_allocator
    import pva_pkg::*;
#(
    parameter int VOICES = DEF_VOICES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FIELD_W-1:0] i_velocity,
    input  logic [FIELD_W-1:0] i_pitch,
    output logic [OUT_W-1:0]   o_voice_index,
    output logic               o_valid
);

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    pva_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pva_datapath #(
        .VOICES (VOICES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_velocity    (i_velocity),
        .i_pitch       (i_pitch),
        .o_voice_index (o_voice_index),
        .o_valid       (o_valid)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted event did not raise busy");

    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("event finished without a result word");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && !$past(o_valid)))
        else $error("result strobe outside the end of an event");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for poly_voice_allocator: directed note events, then random
// note-on/note-off traffic, each result checked against a typed-in voice or an allocation model.
// Depends on pva_pkg and the poly_voice_allocator RTL.
`timescale 1ns / 1ps
module testbench;
    import pva_pkg::*;

    localparam int N_VOICES        = DEF_VOICES;
    localparam int PREDICT         = -1;     // row has no typed-in result
    localparam int N_DIRECTED      = 19;
    localparam int N_PER_PHASE     = 500;
    localparam int MAX_REPORTS     = 10;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 2 * N_VOICES + 4;
    localparam int MAX_HELD        = 16;

    typedef struct {
        logic [FIELD_W-1:0] vel;
        logic [FIELD_W-1:0] pitch;
        int                 voice;
    } t_stim_row;

    // Note-ons fill the pool in order, then the full pool forces steals.
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{7'd0,   7'd0,   7},        // note-off at reset: every free voice holds pitch 0
        '{7'd0,   7'd127, 0},        // note-off with no match
        '{7'd127, 7'd127, 0},
        '{7'd1,   7'd0,   1},
        '{7'd64,  7'd10,  2},
        '{7'd0,   7'd0,   PREDICT},  // releases busy voice 1 and the free ones
        '{7'd5,   7'd10,  PREDICT},
        '{7'd0,   7'd10,  PREDICT},  // two voices hold pitch 10
        '{7'd100, 7'd20,  PREDICT},
        '{7'd100, 7'd21,  PREDICT},
        '{7'd100, 7'd22,  PREDICT},
        '{7'd100, 7'd23,  PREDICT},
        '{7'd100, 7'd24,  PREDICT},
        '{7'd100, 7'd25,  PREDICT},
        '{7'd100, 7'd26,  PREDICT},
        '{7'd100, 7'd27,  PREDICT},  // pool full: steal head of a list with stale entries
        '{7'd90,  7'd30,  PREDICT},
        '{7'd0,   7'd20,  PREDICT},
        '{7'd0,   7'd127, PREDICT}
    };

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               start      = 1'b0;
    logic               busy;
    logic [FIELD_W-1:0] i_velocity = '0;
    logic [FIELD_W-1:0] i_pitch    = '0;
    logic [OUT_W-1:0]   o_voice_index;
    logic               o_valid;

    int                 typed_voice = PREDICT;

    // Allocation model state.
    logic [FIELD_W-1:0] voice_pitch_q [N_VOICES];
    logic [FIELD_W-1:0] voice_vel_q   [N_VOICES];
    logic               voice_busy_q  [N_VOICES];
    int                 age_voice_q   [N_VOICES];
    logic               age_valid_q   [N_VOICES];

    logic [OUT_W-1:0]   expected_voices [$];
    int                 mismatches;
    int                 stall_cycles;

    poly_voice_allocator #(
        .VOICES(N_VOICES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_velocity   (i_velocity),
        .i_pitch      (i_pitch),
        .o_voice_index(o_voice_index),
        .o_valid      (o_valid)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [OUT_W-1:0] allocate_voice(input logic [FIELD_W-1:0] vel,
                                                        input logic [FIELD_W-1:0] pit);
        int chosen;
        bit found;
        chosen = 0;
        found  = 1'b0;
        if (vel == '0) begin
            for (int v = 0; v < N_VOICES; v++) begin
                if (voice_pitch_q[v] == pit) begin
                    voice_vel_q[v]  = '0;
                    voice_busy_q[v] = 1'b0;
                    chosen          = v;
                end
            end
        end else begin
            for (int v = 0; v < N_VOICES; v++) begin
                if (!found && !voice_busy_q[v]) begin
                    found  = 1'b1;
                    chosen = v;
                end
            end
            if (found) begin
                voice_busy_q[chosen] = 1'b1;
            end else begin
                chosen = age_valid_q[0] ? age_voice_q[0] : 0;
                if (chosen >= N_VOICES) chosen = 0;
            end
            voice_pitch_q[chosen] = pit;
            voice_vel_q[chosen]   = vel;
            // shift the age list and append the allocated voice
            for (int a = 0; a + 1 < N_VOICES; a++) begin
                age_voice_q[a] = age_voice_q[a + 1];
                age_valid_q[a] = age_valid_q[a + 1];
            end
            age_voice_q[N_VOICES - 1] = chosen;
            age_valid_q[N_VOICES - 1] = 1'b1;
        end
        return chosen[OUT_W-1:0];
    endfunction

    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
    endtask

    initial begin
        for (int v = 0; v < N_VOICES; v++) begin
            voice_pitch_q[v] = '0;
            voice_vel_q[v]   = '0;
            voice_busy_q[v]  = 1'b0;
            age_voice_q[v]   = 0;
            age_valid_q[v]   = 1'b0;
        end
        mismatches   = 0;
        stall_cycles = 0;
    end

    // Predict on every accepted event word; check every result word.
    always @(posedge i_clk) begin
        logic [OUT_W-1:0] predicted;
        logic [OUT_W-1:0] want;
        if (i_rst_n) begin
            if (start && !busy) begin
                predicted = allocate_voice(i_velocity, i_pitch);
                if (typed_voice == PREDICT) expected_voices.push_back(predicted);
                else                        expected_voices.push_back(typed_voice[OUT_W-1:0]);
            end
            if (o_valid) begin
                if (expected_voices.size() == 0) begin
                    log_mismatch($sformatf("unexpected result word voice_index=%0d",
                                           o_voice_index));
                end else begin
                    want = expected_voices.pop_front();
                    if (o_voice_index !== want)
                        log_mismatch($sformatf("voice_index expected %0d, got %0d",
                                               want, o_voice_index));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_CYCLES) begin
                $display("Watchdog: no progress for %0d cycles", WATCHDOG_CYCLES);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Hold the word until busy is low at an edge; leave start high for a back-to-back word.
    task automatic send_event(input logic [FIELD_W-1:0] vel, input logic [FIELD_W-1:0] pit,
                              input int voice, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_velocity  <= vel;
        i_pitch     <= pit;
        typed_voice <= voice;
        do @(posedge i_clk); while (busy);
    endtask

    // Advance one edge first so the last accepted word is already queued.
    task automatic pause_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_voices.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int                 idle_pct [3] = '{7, 48, 0};
        logic [FIELD_W-1:0] held_pitches [$];
        logic [FIELD_W-1:0] vel;
        logic [FIELD_W-1:0] pit;
        int                 mode;
        int                 k;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_event(directed_rows[r].vel, directed_rows[r].pitch, directed_rows[r].voice,
                       0);
        pause_until_drained();

        for (int phase = 0; phase < 3; phase++) begin
            for (int n = 0; n < N_PER_PHASE; n++) begin
                mode = $urandom_range(99);
                if (mode < 45) begin
                    // note-on; a narrow pitch band makes duplicate pitches common
                    vel = 7'($urandom_range(127, 1));
                    pit = ($urandom_range(1) == 1) ? 7'(60 + $urandom_range(7))
                                                    : 7'($urandom_range(127));
                    held_pitches.push_back(pit);
                    if (held_pitches.size() > MAX_HELD) void'(held_pitches.pop_front());
                end else if (mode < 85 && held_pitches.size() > 0) begin
                    vel = '0;
                    k   = $urandom_range(held_pitches.size() - 1);
                    pit = held_pitches[k];
                    held_pitches.delete(k);
                end else if (mode < 95) begin
                    vel = '0;
                    pit = 7'($urandom_range(127));
                end else begin
                    vel = ($urandom_range(1) == 1) ? 7'd127 : 7'd1;
                    pit = ($urandom_range(1) == 1) ? 7'd127 : 7'd0;
                end
                send_event(vel, pit, PREDICT, idle_pct[phase]);
            end
            pause_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_voices.size() != 0)
            log_mismatch($sformatf("%0d result words never arrived", expected_voices.size()));
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pva_pkg.sv
rtl/pva_controller.sv
rtl/pva_datapath.sv
rtl/poly_voice_allocator.sv
dv/testbench.sv
